FILE: rtl/nearest_point_linear_interpolator_assert.svh
// ----------------------------------------------------------------------------
// nearest point linear interpolator assertion macros
// concurrent checks used by the interpolator rtl
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_LINEAR_INTERPOLATOR_ASSERT_SVH
`define NEAREST_POINT_LINEAR_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define NPLI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("npli check failed");

// next-cycle implication
`define NPLI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("npli check failed");

`endif

FILE: rtl/npli_pkg.sv
// ----------------------------------------------------------------------------
// npli_pkg
// shared types, constants and helpers of the nearest point interpolator
// ----------------------------------------------------------------------------
package npli_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int CFG_W  = 7;
  localparam int SLOT_W = 6;
  localparam int ANG_W  = 16;
  localparam int INT_W  = 16;
  localparam int EXT_W  = 17;
  localparam int PROD_W = 34;
  localparam int SUM_W  = 34;
  localparam int DIV_W  = 32;
  localparam int DVS_W  = 16;
  localparam int STEP_W = $clog2(DIV_W);

  localparam int INT_MAX = 32767;
  localparam int INT_MIN = -32768;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [SLOT_W-1:0]       entry_index;
    logic signed [ANG_W-1:0] entry_angle;
    logic signed [INT_W-1:0] entry_intensity;
    logic signed [ANG_W-1:0] query_angle;
  } req_t;

  typedef struct packed {
    logic signed [INT_W-1:0] intensity_value;
    logic [SLOT_W-1:0]       nearest_slot;
    logic                    table_empty;
    logic                    zero_span;
    logic                    saturated;
  } rsp_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] angle;
    logic signed [INT_W-1:0] intensity;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [EXT_W-1:0] sext(input logic signed [ANG_W-1:0] v);
    return EXT_W'(v);
  endfunction

endpackage

FILE: rtl/npli_if.sv
// ----------------------------------------------------------------------------
// npli interfaces
// valid / ready channels for request and response words
// ----------------------------------------------------------------------------
interface npli_req_if;
  logic          valid;
  logic          ready;
  npli_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface npli_rsp_if;
  logic          valid;
  logic          ready;
  npli_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/npli_table.sv
// ----------------------------------------------------------------------------
// npli_table
// angle / intensity table, one write port and one registered read port
// ----------------------------------------------------------------------------
module npli_table (
  input  logic                clk_i,
  input  npli_pkg::mem_wr_t   wr_i,
  input  npli_pkg::mem_rd_t   rd_i,
  output npli_pkg::entry_t    rdata_o
);

  npli_pkg::entry_t mem_q [npli_pkg::TABLE_DEPTH];
  npli_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/npli_div.sv
// ----------------------------------------------------------------------------
// npli_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module npli_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  npli_pkg::div_req_t req_i,
  output npli_pkg::div_rsp_t rsp_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [npli_pkg::STEP_W-1:0]     cnt_q;
  logic [npli_pkg::DVS_W-1:0]      rem_q;
  logic [npli_pkg::DVS_W-1:0]      dvs_q;
  logic [npli_pkg::DIV_W-1:0]      quo_q;
  logic [npli_pkg::DVS_W:0]        rem_sh;
  logic [npli_pkg::DVS_W:0]        rem_nx;
  logic                            ge;
  logic                            last_step;

  assign rem_sh    = {rem_q, quo_q[npli_pkg::DIV_W-1]};
  assign ge        = rem_sh >= {1'b0, dvs_q};
  assign rem_nx    = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  assign last_step = (cnt_q == npli_pkg::STEP_W'(npli_pkg::DIV_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && last_step;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      quo_q <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= rem_nx[npli_pkg::DVS_W-1:0];
      quo_q <= {quo_q[npli_pkg::DIV_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: rtl/nearest_point_linear_interpolator.sv
// ----------------------------------------------------------------------------
// nearest_point_linear_interpolator
// table lookup with nearest-angle search and linear interpolation
// ----------------------------------------------------------------------------
// usage
//   req_i carries load and query words; rsp_o carries one word per query.
//   cfg_we_i / cfg_wdata_i set the number of table entries in use; write it
//   only while no query is in flight.
//   a load word is written to the table on acceptance and produces no response.
//   an interpolating query with n entries in use scans all n entries on the
//   single read port, then does a neighbor read, a multiply and a 32-step
//   divider before its response. a single entry or a zero span skips the
//   multiply and divider, and an empty table answers without a scan.
//   one query is worked on at a time; req_i.ready is high while idle.
//   the response sits in an output register, so the next word is accepted
//   while a response still waits for rsp_o.ready; a query that finishes
//   while that register is full holds until the receiver takes the word.
//   reset clears the entry count, control state and the response valid;
//   table contents are undefined until loaded, and there is no clearing pass.
// ----------------------------------------------------------------------------
`include "nearest_point_linear_interpolator_assert.svh"

module nearest_point_linear_interpolator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [npli_pkg::CFG_W-1:0]     cfg_wdata_i,
  npli_req_if.sink                       req_i,
  npli_rsp_if.source                     rsp_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SEARCH = 8'b0000_0010,
    ST_NBR    = 8'b0000_0100,
    ST_SPAN   = 8'b0000_1000,
    ST_MUL    = 8'b0001_0000,
    ST_START  = 8'b0010_0000,
    ST_DIV    = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [npli_pkg::CFG_W-1:0]            entries_q;
  logic [npli_pkg::CNT_W-1:0]            n_sat;
  logic [npli_pkg::CNT_W-1:0]            n_q;
  logic [npli_pkg::CNT_W-1:0]            issue_q;
  logic                                  cmp_vld_q;
  logic [npli_pkg::IDX_W-1:0]            cmp_idx_q;
  logic signed [npli_pkg::ANG_W-1:0]     q_q;
  logic [npli_pkg::EXT_W-1:0]            best_d_q;
  logic [npli_pkg::IDX_W-1:0]            best_idx_q;
  logic signed [npli_pkg::ANG_W-1:0]     best_ang_q;
  logic signed [npli_pkg::INT_W-1:0]     best_int_q;
  logic                                  oth_hi_q;
  logic signed [npli_pkg::EXT_W-1:0]     span_q;
  logic signed [npli_pkg::EXT_W-1:0]     di_q;
  logic signed [npli_pkg::EXT_W-1:0]     dq_q;
  logic signed [npli_pkg::PROD_W-1:0]    prod_q;
  npli_pkg::rsp_t                        res_q;
  npli_pkg::rsp_t                        rsp_q;
  logic                                  rsp_vld_q;

  logic                                  acc;
  logic                                  is_query;
  logic                                  out_free;
  logic signed [npli_pkg::EXT_W-1:0]     diff;
  logic [npli_pkg::EXT_W-1:0]            absd;
  logic                                  take;
  logic                                  search_last;
  logic                                  oth_hi;
  logic [npli_pkg::IDX_W-1:0]            oth_idx;
  logic signed [npli_pkg::EXT_W-1:0]     span_w;
  logic signed [npli_pkg::EXT_W-1:0]     di_w;
  logic                                  neg;
  logic signed [npli_pkg::SUM_W-1:0]     quo_s;
  logic signed [npli_pkg::SUM_W-1:0]     sum;
  logic                                  sat_hi;
  logic                                  sat_lo;
  logic signed [npli_pkg::INT_W-1:0]     sat_val;

  npli_pkg::mem_wr_t                     mem_wr;
  npli_pkg::mem_rd_t                     mem_rd;
  npli_pkg::entry_t                      mem_rdata;
  npli_pkg::div_req_t                    div_req;
  npli_pkg::div_rsp_t                    div_rsp;

  npli_table u_table (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .rd_i    (mem_rd),
    .rdata_o (mem_rdata)
  );

  npli_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign req_i.ready   = (state_q == ST_IDLE);
  assign acc           = req_i.valid && req_i.ready;
  assign is_query      = (req_i.payload.req_type == npli_pkg::REQ_QUERY);
  assign out_free      = !rsp_vld_q || rsp_o.ready;
  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

  always_comb begin
    if (32'(entries_q) > 32'(npli_pkg::TABLE_DEPTH)) begin
      n_sat = npli_pkg::CNT_W'(npli_pkg::TABLE_DEPTH);
    end else begin
      n_sat = npli_pkg::CNT_W'(entries_q);
    end
  end

  // table write on load words
  always_comb begin
    mem_wr.en   = acc && !is_query &&
                  (32'(req_i.payload.entry_index) < 32'(npli_pkg::TABLE_DEPTH));
    mem_wr.addr = npli_pkg::IDX_W'(req_i.payload.entry_index);
    mem_wr.data.angle     = req_i.payload.entry_angle;
    mem_wr.data.intensity = req_i.payload.entry_intensity;
  end

  // neighbor entry that closes the segment
  assign oth_hi  = (npli_pkg::CNT_W'(best_idx_q) + 1'b1) < n_q;
  assign oth_idx = oth_hi ? (best_idx_q + 1'b1) : (best_idx_q - 1'b1);

  always_comb begin
    mem_rd.en   = 1'b0;
    mem_rd.addr = '0;
    case (state_q)
      ST_SEARCH: begin
        mem_rd.en   = issue_q < n_q;
        mem_rd.addr = issue_q[npli_pkg::IDX_W-1:0];
      end
      ST_NBR: begin
        mem_rd.en   = n_q > npli_pkg::CNT_W'(1);
        mem_rd.addr = oth_idx;
      end
      default: begin
        mem_rd.en = 1'b0;
      end
    endcase
  end

  // distance compare on read data
  assign diff = npli_pkg::sext(q_q) - npli_pkg::sext(mem_rdata.angle);
  assign absd = diff[npli_pkg::EXT_W-1] ? npli_pkg::EXT_W'(-diff) : npli_pkg::EXT_W'(diff);
  assign take = cmp_vld_q && ((cmp_idx_q == '0) || (absd < best_d_q));
  assign search_last = cmp_vld_q &&
                       (npli_pkg::CNT_W'(cmp_idx_q) == (n_q - 1'b1));

  // segment span and intensity step, oriented low to high
  always_comb begin
    if (oth_hi_q) begin
      span_w = npli_pkg::sext(mem_rdata.angle) - npli_pkg::sext(best_ang_q);
      di_w   = npli_pkg::sext(mem_rdata.intensity) - npli_pkg::sext(best_int_q);
    end else begin
      span_w = npli_pkg::sext(best_ang_q) - npli_pkg::sext(mem_rdata.angle);
      di_w   = npli_pkg::sext(best_int_q) - npli_pkg::sext(mem_rdata.intensity);
    end
  end

  // divider operands as magnitudes
  assign neg = prod_q[npli_pkg::PROD_W-1] ^ span_q[npli_pkg::EXT_W-1];
  always_comb begin
    div_req.start    = (state_q == ST_START);
    div_req.dividend = prod_q[npli_pkg::PROD_W-1] ? npli_pkg::DIV_W'(-prod_q)
                                                   : npli_pkg::DIV_W'(prod_q);
    div_req.divisor  = span_q[npli_pkg::EXT_W-1] ? npli_pkg::DVS_W'(-span_q)
                                                  : npli_pkg::DVS_W'(span_q);
  end

  // signed quotient plus base intensity, then clip
  always_comb begin
    quo_s  = $signed(npli_pkg::SUM_W'(div_rsp.quotient));
    if (neg) begin
      quo_s = -quo_s;
    end
    sum    = quo_s + npli_pkg::SUM_W'(best_int_q);
    sat_hi = sum > npli_pkg::SUM_W'(npli_pkg::INT_MAX);
    sat_lo = sum < npli_pkg::SUM_W'(npli_pkg::INT_MIN);
    if (sat_hi) begin
      sat_val = npli_pkg::INT_W'(npli_pkg::INT_MAX);
    end else if (sat_lo) begin
      sat_val = npli_pkg::INT_W'(npli_pkg::INT_MIN);
    end else begin
      sat_val = sum[npli_pkg::INT_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && is_query) begin
          state_d = (n_sat == '0) ? ST_OUT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (search_last) begin
          state_d = ST_NBR;
        end
      end
      ST_NBR: begin
        state_d = (n_q == npli_pkg::CNT_W'(1)) ? ST_OUT : ST_SPAN;
      end
      ST_SPAN: begin
        state_d = (span_w == '0) ? ST_OUT : ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      entries_q <= '0;
      issue_q   <= '0;
      cmp_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        entries_q <= cfg_wdata_i;
      end
      if (acc) begin
        issue_q <= '0;
      end else if ((state_q == ST_SEARCH) && mem_rd.en) begin
        issue_q <= issue_q + 1'b1;
      end
      cmp_vld_q <= (state_q == ST_SEARCH) && mem_rd.en;
      if ((state_q == ST_OUT) && out_free) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= issue_q[npli_pkg::IDX_W-1:0];
    if (acc && is_query) begin
      n_q   <= n_sat;
      q_q   <= req_i.payload.query_angle;
      res_q <= '{intensity_value: '0, nearest_slot: '0, table_empty: (n_sat == '0),
                 zero_span: 1'b0, saturated: 1'b0};
    end
    if (take) begin
      best_d_q   <= absd;
      best_idx_q <= cmp_idx_q;
      best_ang_q <= mem_rdata.angle;
      best_int_q <= mem_rdata.intensity;
    end
    if (state_q == ST_NBR) begin
      oth_hi_q              <= oth_hi;
      res_q.intensity_value <= best_int_q;
      res_q.nearest_slot    <= npli_pkg::SLOT_W'(best_idx_q);
    end
    if (state_q == ST_SPAN) begin
      span_q          <= span_w;
      di_q            <= di_w;
      dq_q            <= npli_pkg::sext(q_q) - npli_pkg::sext(best_ang_q);
      res_q.zero_span <= (span_w == '0);
    end
    if (state_q == ST_MUL) begin
      prod_q <= npli_pkg::PROD_W'(dq_q) * npli_pkg::PROD_W'(di_q);
    end
    if ((state_q == ST_DIV) && div_rsp.done) begin
      res_q.intensity_value <= sat_val;
      res_q.saturated       <= sat_hi || sat_lo;
    end
    if ((state_q == ST_OUT) && out_free) begin
      rsp_q <= res_q;
    end
  end

  `NPLI_ASSERT_IMP(a_no_rw_clash, clk_i, rst_ni, mem_wr.en, !mem_rd.en)
  `NPLI_ASSERT_IMP(a_flags_excl, clk_i, rst_ni, rsp_vld_q,
                   $onehot0({rsp_q.table_empty, rsp_q.zero_span, rsp_q.saturated}))
  `NPLI_ASSERT_IMP(a_div_done_st, clk_i, rst_ni, div_rsp.done, state_q == ST_DIV)
  `NPLI_ASSERT_NXT(a_out_load, clk_i, rst_ni, (state_q == ST_OUT) && out_free, rsp_vld_q)
  `NPLI_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, rsp_vld_q && rsp_q.table_empty,
                   (rsp_q.intensity_value == '0) && (rsp_q.nearest_slot == '0))

endmodule
